// File: rtl/core/ffpra_pkg.sv
`timescale 1ns / 1ps

package ffpra_pkg;

    localparam int WORD_W  = 32;
    localparam int OFF_W   = 5;
    localparam int CNT_W   = 11;
    localparam int START_W = 10;
    localparam int STAT_W  = 3;
    localparam int CFG_W   = 11;

    localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 11'd1024;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_INIT  = 3'd1,
        ST_BAD_COUNT = 3'd2,
        ST_NO_RUN    = 3'd3,
        ST_NOT_USED  = 3'd4,
        ST_RANGE     = 3'd5
    } t_status;

    typedef enum logic {
        CFG_ENABLED    = 1'b0,
        CFG_PAGE_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              hit;
        logic [OFF_W-1:0]  hit_off;
        logic [CNT_W-1:0]  run_out;
        logic              bad;
        logic [OFF_W-1:0]  bad_off;
        logic [WORD_W-1:0] req_mask;
        logic [WORD_W-1:0] clr_mask;
        logic [OFF_W:0]    n_freed;
        logic              hi_here;
    } t_word_eval;

endpackage

// File: rtl/core/ffpra_ram.sv
`timescale 1ns / 1ps

module ffpra_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic [ffpra_pkg::WORD_W-1:0]     i_wdata,
    input  logic                             i_re,
    input  logic [AW-1:0]                    i_raddr,
    output logic [ffpra_pkg::WORD_W-1:0]     o_rdata
);

    logic [ffpra_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [ffpra_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ffpra_word_eval.sv
`timescale 1ns / 1ps

module ffpra_word_eval #(
    parameter int CW = 12
) (
    input  logic [ffpra_pkg::WORD_W-1:0] i_word,
    input  logic [CW-1:0]                i_base,
    input  logic [CW-1:0]                i_lim,
    input  logic [ffpra_pkg::CNT_W-1:0]  i_count,
    input  logic [ffpra_pkg::CNT_W-1:0]  i_run,
    input  logic [CW-1:0]                i_lo,
    input  logic [CW-1:0]                i_hi,
    output ffpra_pkg::t_word_eval        o_eval
);

    localparam int W  = ffpra_pkg::WORD_W;
    localparam int OW = ffpra_pkg::OFF_W;
    localparam int NW = ffpra_pkg::CNT_W;

    logic [W-1:0]  w_blocked;
    logic [W-1:0]  w_req;
    logic [W-1:0]  w_bad;
    logic [W-1:0]  w_hit;
    logic [NW:0]   w_run [W];

    always_comb begin
        logic [CW-1:0] page;
        page = '0;
        for (int j = 0; j < W; j++) begin
            page         = i_base + CW'(j);
            w_blocked[j] = i_word[j] | (page >= i_lim);
            w_req[j]     = (page >= i_lo) && (page <= i_hi);
            w_bad[j]     = w_req[j] && ((page >= i_lim) || !i_word[j]);
        end
    end

    // run length ending at each lane, carried in from earlier words
    always_comb begin
        logic          allfree;
        logic [OW:0]   gap;
        allfree = 1'b1;
        gap     = '0;
        for (int j = 0; j < W; j++) begin
            allfree = 1'b1;
            gap     = (OW+1)'(j + 1);
            for (int i = 0; i <= j; i++) begin
                if (w_blocked[i]) begin
                    allfree = 1'b0;
                    gap     = (OW+1)'(j - i);
                end
            end
            w_run[j] = allfree ? ({1'b0, i_run} + (NW+1)'(j + 1)) : (NW+1)'(gap);
            w_hit[j] = !w_blocked[j] && (w_run[j] == {1'b0, i_count});
        end
    end

    always_comb begin
        logic [OW-1:0] hi_off;
        o_eval          = '0;
        o_eval.hit      = |w_hit;
        o_eval.bad      = |w_bad;
        o_eval.run_out  = w_run[W-1][NW-1:0];
        o_eval.req_mask = w_req;
        for (int j = W - 1; j >= 0; j--) begin
            if (w_hit[j]) begin
                o_eval.hit_off = OW'(j);
            end
            if (w_bad[j]) begin
                o_eval.bad_off = OW'(j);
            end
        end
        for (int j = 0; j < W; j++) begin
            o_eval.clr_mask[j] = w_req[j] && !(o_eval.bad && (OW'(j) >= o_eval.bad_off));
        end
        o_eval.hi_here = (i_hi[CW-1:OW] == i_base[CW-1:OW]);
        hi_off         = o_eval.hi_here ? i_hi[OW-1:0] : {OW{1'b1}};
        if (o_eval.bad) begin
            o_eval.n_freed = {1'b0, o_eval.bad_off} - {1'b0, i_lo[OW-1:0]};
        end else begin
            o_eval.n_freed = {1'b0, hi_off} - {1'b0, i_lo[OW-1:0]} + (OW+1)'(1);
        end
    end

endmodule

// File: rtl/core/first_fit_page_run_allocator.sv
`timescale 1ns / 1ps

// First-fit page run allocator. One used bit per page lives in a 32-bit wide
// synchronous RAM of ceil(PAGES/32) words; after reset the block clears the
// RAM word by word with input ready held low (configuration writes are taken
// meanwhile). One item is in work at a time. Refused items (not enabled, zero
// count, run longer than the managed pages) go from the check state straight
// to the finish state and the output register. An allocate scans one RAM word
// per cycle from page 0 until it finds or misses a run, then marks each word
// the granted run touches with a read-modify-write. A free clears each word it
// touches with a read-modify-write. A new item is accepted while the previous
// result still waits.
module first_fit_page_run_allocator #(
    parameter int PAGES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // start_page[9:0], count[20:10], zero[23:21]
    input  logic [0:0]  i_s_tuser,   // func[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // alloc_start[9:0], pages_done[20:10], used_pages[31:21]
    output logic [2:0]  o_m_tuser,   // status[2:0]
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_addr,
    input  logic [10:0] i_cfg_wdata
);

    localparam int W     = ffpra_pkg::WORD_W;
    localparam int OW    = ffpra_pkg::OFF_W;
    localparam int NW    = ffpra_pkg::CNT_W;
    localparam int SW    = ffpra_pkg::START_W;
    localparam int DEPTH = (PAGES + W - 1) / W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = AW + OW;
    localparam int CW    = ((PW > NW) ? PW : NW) + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_FREE_CHK,
        S_FREE_WR,
        S_FINISH
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_word;
    logic                 r_func;
    logic [SW-1:0]        r_start;
    logic [NW-1:0]        r_count;
    logic [NW-1:0]        r_run;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [NW-1:0]        r_done;
    logic [NW-1:0]        r_used;
    logic [SW-1:0]        r_astart;
    ffpra_pkg::t_status   r_status;
    logic                 r_enabled;
    logic [NW-1:0]        r_page_count;
    logic                 r_m_valid;
    logic [31:0]          r_m_tdata;
    logic [2:0]           r_m_tuser;

    logic                 w_ram_we;
    logic [W-1:0]         w_ram_wdata;
    logic                 w_ram_re;
    logic [AW-1:0]        w_ram_raddr;
    logic [W-1:0]         w_rdata;
    logic [CW-1:0]        w_lim;
    logic [CW-1:0]        w_base;
    logic [CW-1:0]        w_hit_page;
    logic [CW-1:0]        w_first;
    logic [CW-1:0]        w_bad_page;
    logic                 w_scan_end;
    logic                 w_alloc_go;
    ffpra_pkg::t_word_eval w_ev;

    assign w_lim = (CW'(r_page_count) < CW'(PAGES)) ? CW'(r_page_count) : CW'(PAGES);
    assign w_base     = CW'({r_word, {OW{1'b0}}});
    assign w_hit_page = w_base + CW'(w_ev.hit_off);
    assign w_first    = w_hit_page + CW'(1) - CW'(r_count);
    assign w_bad_page = w_base + CW'(w_ev.bad_off);
    assign w_scan_end = (w_base + CW'(W)) >= w_lim;
    assign w_alloc_go = r_enabled && (r_count != '0) && (r_func == ffpra_pkg::FUNC_ALLOC)
                        && (CW'(r_count) <= w_lim);

    ffpra_word_eval #(
        .CW (CW)
    ) u_eval (
        .i_word  (w_rdata),
        .i_base  (w_base),
        .i_lim   (w_lim),
        .i_count (r_count),
        .i_run   (r_run),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_eval  (w_ev)
    );

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_wdata = '0;
        w_ram_re    = 1'b0;
        w_ram_raddr = r_word;
        unique case (r_state)
            S_CLEAR: begin
                w_ram_we = 1'b1;
            end
            S_CHECK: begin
                w_ram_re    = w_alloc_go;
                w_ram_raddr = '0;
            end
            S_SCAN: begin
                w_ram_re    = !w_ev.hit && !w_scan_end;
                w_ram_raddr = r_word + AW'(1);
            end
            S_MARK_RD: begin
                w_ram_re = 1'b1;
            end
            S_MARK_WR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = w_rdata | w_ev.req_mask;
            end
            S_FREE_CHK: begin
                w_ram_re    = r_lo < w_lim;
                w_ram_raddr = r_lo[PW-1:OW];
            end
            S_FREE_WR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = w_rdata & ~w_ev.clr_mask;
            end
            default: begin
            end
        endcase
    end

    ffpra_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_word),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_word       <= '0;
            r_used       <= '0;
            r_enabled    <= 1'b0;
            r_page_count <= ffpra_pkg::PAGE_COUNT_RST;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (ffpra_pkg::t_cfg_idx'(i_cfg_addr))
                    ffpra_pkg::CFG_ENABLED:    r_enabled    <= i_cfg_wdata[0];
                    ffpra_pkg::CFG_PAGE_COUNT: r_page_count <= i_cfg_wdata;
                endcase
            end

            if (r_m_valid && i_m_tready && (r_state != S_FINISH)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_word == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_word <= r_word + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_func  <= i_s_tuser[0];
                        r_start <= i_s_tdata[9:0];
                        r_count <= i_s_tdata[20:10];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_done   <= '0;
                    r_astart <= '0;
                    priority if (!r_enabled) begin
                        r_status <= ffpra_pkg::ST_NOT_INIT;
                        r_state  <= S_FINISH;
                    end else if (r_count == '0) begin
                        r_status <= ffpra_pkg::ST_BAD_COUNT;
                        r_state  <= S_FINISH;
                    end else if (r_func == ffpra_pkg::FUNC_ALLOC) begin
                        if (w_alloc_go) begin
                            r_word  <= '0;
                            r_run   <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_status <= ffpra_pkg::ST_NO_RUN;
                            r_state  <= S_FINISH;
                        end
                    end else begin
                        r_lo    <= CW'(r_start);
                        r_hi    <= CW'(r_start) + CW'(r_count) - CW'(1);
                        r_state <= S_FREE_CHK;
                    end
                end
                S_SCAN: begin
                    priority if (w_ev.hit) begin
                        r_lo    <= w_first;
                        r_hi    <= w_hit_page;
                        r_word  <= w_first[PW-1:OW];
                        r_state <= S_MARK_RD;
                    end else if (w_scan_end) begin
                        r_status <= ffpra_pkg::ST_NO_RUN;
                        r_state  <= S_FINISH;
                    end else begin
                        r_run  <= w_ev.run_out;
                        r_word <= r_word + AW'(1);
                    end
                end
                S_MARK_RD: begin
                    r_state <= S_MARK_WR;
                end
                S_MARK_WR: begin
                    if (w_ev.hi_here) begin
                        r_status <= ffpra_pkg::ST_OK;
                        r_astart <= r_lo[SW-1:0];
                        r_done   <= r_count;
                        r_used   <= r_used + r_count;
                        r_state  <= S_FINISH;
                    end else begin
                        r_word  <= r_word + AW'(1);
                        r_state <= S_MARK_RD;
                    end
                end
                S_FREE_CHK: begin
                    if (r_lo >= w_lim) begin
                        r_status <= ffpra_pkg::ST_RANGE;
                        r_state  <= S_FINISH;
                    end else begin
                        r_word  <= r_lo[PW-1:OW];
                        r_state <= S_FREE_WR;
                    end
                end
                S_FREE_WR: begin
                    r_done <= r_done + NW'(w_ev.n_freed);
                    r_used <= r_used - NW'(w_ev.n_freed);
                    priority if (w_ev.bad) begin
                        r_status <= (w_bad_page >= w_lim) ? ffpra_pkg::ST_RANGE
                                                          : ffpra_pkg::ST_NOT_USED;
                        r_state  <= S_FINISH;
                    end else if (w_ev.hi_here) begin
                        r_status <= ffpra_pkg::ST_OK;
                        r_state  <= S_FINISH;
                    end else begin
                        r_lo    <= w_base + CW'(W);
                        r_state <= S_FREE_CHK;
                    end
                end
                S_FINISH: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_tdata <= {r_used, r_done, r_astart};
                        r_m_tuser <= r_status;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

// File: rtl/core/ffpra_checker.sv
`timescale 1ns / 1ps

module ffpra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [2:0]  o_m_tuser
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // one item at a time: ready drops after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ffpra_pkg::ST_OK) |-> (o_m_tdata[9:0] == '0))
        else $error("alloc_start nonzero on error");

    a_refused_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser == ffpra_pkg::ST_NOT_INIT)
                    || (o_m_tuser == ffpra_pkg::ST_BAD_COUNT)
                    || (o_m_tuser == ffpra_pkg::ST_NO_RUN)) |-> (o_m_tdata[20:10] == '0))
        else $error("pages_done nonzero on refused request");

endmodule

bind first_fit_page_run_allocator ffpra_checker u_ffpra_checker (.*);
